[rtl/raycast_dda_ray_setup_assert.svh]
// assertion macros for the ray setup checker
`ifndef RAYCAST_DDA_RAY_SETUP_ASSERT_SVH
`define RAYCAST_DDA_RAY_SETUP_ASSERT_SVH

// same-cycle implication, idle during reset
`define RDRS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdrs assertion failed");

// next-cycle implication, idle during reset
`define RDRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdrs assertion failed");

`endif

[rtl/rdrs_pkg.sv]
// shared constants, types and helpers of the ray setup pipeline
package rdrs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAP_BITS  = 8;
  localparam int DIR_FRAC  = 14;

  localparam int COL_W    = 12;
  localparam int WIDTH_W  = 13;
  localparam int POS_W    = 24;
  localparam int DIR_W    = 16;
  localparam int RAY_W    = 18;
  localparam int CELL_W   = 8;
  localparam int DIST_W   = MAP_BITS + FRAC_BITS;
  localparam int STEP_W   = 2;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  // camera divider: (column * 2^15) / width
  localparam int CAM_NUM_W = COL_W + DIR_FRAC + 1;
  localparam int CAM_W     = CAM_NUM_W + 1;
  localparam int PROD_W    = DIR_W + CAM_W;
  localparam int SUM_W     = PROD_W - DIR_FRAC + 1;

  // reciprocal divider: 2^(14+FRAC) / |ray|
  localparam int RCP_NUM_W = DIR_FRAC + FRAC_BITS + 1;
  localparam int MAG_W     = RAY_W;

  localparam int F_W      = FRAC_BITS + 1;
  localparam int SPROD_W  = F_W + DIST_W;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_PLANE_X  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_PLANE_Y  = 3'd6;

  localparam logic [STEP_W-1:0] STEP_POS = 2'b01;
  localparam logic [STEP_W-1:0] STEP_NEG = 2'b11;

  // lowest field last so it lands in the lowest bits
  typedef struct packed {
    logic [DIST_W-1:0]       side_y;
    logic [DIST_W-1:0]       side_x;
    logic [STEP_W-1:0]       step_dir_y;
    logic [STEP_W-1:0]       step_dir_x;
    logic [DIST_W-1:0]       delta_y;
    logic [DIST_W-1:0]       delta_x;
    logic [CELL_W-1:0]       cell_y;
    logic [CELL_W-1:0]       cell_x;
    logic signed [RAY_W-1:0] ray_y;
    logic signed [RAY_W-1:0] ray_x;
  } rdrs_result_t;

  function automatic logic signed [RAY_W-1:0] sat_ray(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (RAY_W - 1)) - 64'sd1);
    lo = -SUM_W'(64'sd1 <<< (RAY_W - 1));
    if (s > hi) begin
      return {1'b0, {(RAY_W-1){1'b1}}};
    end else if (s < lo) begin
      return {1'b1, {(RAY_W-1){1'b0}}};
    end
    return s[RAY_W-1:0];
  endfunction

endpackage

[rtl/rdrs_div.sv]
// pipelined restoring divider, one quotient bit per stage
module rdrs_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 13,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [SB_W-1:0]  sb_in,
  output logic [NUM_W-1:0] quo,
  output logic [SB_W-1:0]  sb_out
);

  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] quo_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [SB_W-1:0]  sb_r  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [NUM_W-1:0] quo_in;
    logic [NUM_W-1:0] num_in;
    logic [SB_W-1:0]  sb_i;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = num;
      assign den_in = den;
      assign sb_i   = sb_in;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
      assign sb_i   = sb_r[k-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1-k]};
    assign diff  = trial - {1'b0, den_in};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        sb_r[k] <= '0;
      end else if (en) begin
        sb_r[k] <= sb_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= num_in;
        den_r[k] <= den_in;
        rem_r[k] <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_r[k] <= {quo_in[NUM_W-2:0], fits};
      end
    end
  end

  assign quo    = quo_r[NUM_W-1];
  assign sb_out = sb_r[NUM_W-1];

endmodule

[rtl/rdrs_ray.sv]
// camera offset, plane product and saturated ray direction, three stages
module rdrs_ray (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [rdrs_pkg::CAM_NUM_W-1:0]        quo,
  input  logic signed [rdrs_pkg::DIR_W-1:0]     view_dir_x,
  input  logic signed [rdrs_pkg::DIR_W-1:0]     view_dir_y,
  input  logic signed [rdrs_pkg::DIR_W-1:0]     cam_plane_x,
  input  logic signed [rdrs_pkg::DIR_W-1:0]     cam_plane_y,
  output logic                                  out_valid,
  output logic signed [rdrs_pkg::RAY_W-1:0]     ray_x,
  output logic signed [rdrs_pkg::RAY_W-1:0]     ray_y
);

  localparam logic signed [rdrs_pkg::CAM_W-1:0] CAM_ONE =
    rdrs_pkg::CAM_W'(64'sd1 <<< rdrs_pkg::DIR_FRAC);

  logic                                 v1;
  logic                                 v2;
  logic signed [rdrs_pkg::CAM_W-1:0]    cam;
  logic signed [rdrs_pkg::PROD_W-1:0]   prod_x;
  logic signed [rdrs_pkg::PROD_W-1:0]   prod_y;
  logic signed [rdrs_pkg::SUM_W-1:0]    sum_x;
  logic signed [rdrs_pkg::SUM_W-1:0]    sum_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // floor shift of the product: drop the low fraction bits
  assign sum_x = rdrs_pkg::SUM_W'(view_dir_x) +
                 rdrs_pkg::SUM_W'($signed(prod_x[rdrs_pkg::PROD_W-1:rdrs_pkg::DIR_FRAC]));
  assign sum_y = rdrs_pkg::SUM_W'(view_dir_y) +
                 rdrs_pkg::SUM_W'($signed(prod_y[rdrs_pkg::PROD_W-1:rdrs_pkg::DIR_FRAC]));

  always_ff @(posedge clk) begin
    if (en) begin
      cam    <= $signed({1'b0, quo}) - CAM_ONE;
      prod_x <= cam_plane_x * cam;
      prod_y <= cam_plane_y * cam;
      ray_x  <= rdrs_pkg::sat_ray(sum_x);
      ray_y  <= rdrs_pkg::sat_ray(sum_y);
    end
  end

endmodule

[rtl/rdrs_side.sv]
// delta saturation, step sign and side distance, three stages
module rdrs_side (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [rdrs_pkg::RCP_NUM_W-1:0]        quo_x,
  input  logic [rdrs_pkg::RCP_NUM_W-1:0]        quo_y,
  input  logic signed [rdrs_pkg::RAY_W-1:0]     ray_x,
  input  logic signed [rdrs_pkg::RAY_W-1:0]     ray_y,
  input  logic [rdrs_pkg::POS_W-1:0]            player_x,
  input  logic [rdrs_pkg::POS_W-1:0]            player_y,
  output logic                                  out_valid,
  output rdrs_pkg::rdrs_result_t                result
);

  localparam logic [rdrs_pkg::F_W-1:0] ONE = rdrs_pkg::F_W'(1) << rdrs_pkg::FRAC_BITS;

  logic                               v1;
  logic                               v2;
  logic [rdrs_pkg::DIST_W-1:0]        dx1, dy1, dx2, dy2;
  logic [rdrs_pkg::F_W-1:0]           fx1, fy1;
  logic signed [rdrs_pkg::RAY_W-1:0]  rx1, ry1, rx2, ry2;
  logic [rdrs_pkg::SPROD_W-1:0]       px2, py2;
  logic [rdrs_pkg::DIST_W-1:0]        dx_sat, dy_sat;
  logic [rdrs_pkg::F_W-1:0]           fx_next, fy_next;
  logic [rdrs_pkg::FRAC_BITS-1:0]     frac_x, frac_y;

  assign dx_sat = (|quo_x[rdrs_pkg::RCP_NUM_W-1:rdrs_pkg::DIST_W]) ?
                  '1 : quo_x[rdrs_pkg::DIST_W-1:0];
  assign dy_sat = (|quo_y[rdrs_pkg::RCP_NUM_W-1:rdrs_pkg::DIST_W]) ?
                  '1 : quo_y[rdrs_pkg::DIST_W-1:0];

  assign frac_x  = player_x[rdrs_pkg::FRAC_BITS-1:0];
  assign frac_y  = player_y[rdrs_pkg::FRAC_BITS-1:0];
  assign fx_next = ray_x[rdrs_pkg::RAY_W-1] ? {1'b0, frac_x} : ONE - {1'b0, frac_x};
  assign fy_next = ray_y[rdrs_pkg::RAY_W-1] ? {1'b0, frac_y} : ONE - {1'b0, frac_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= dx_sat;
      dy1 <= dy_sat;
      fx1 <= fx_next;
      fy1 <= fy_next;
      rx1 <= ray_x;
      ry1 <= ray_y;

      dx2 <= dx1;
      dy2 <= dy1;
      rx2 <= rx1;
      ry2 <= ry1;
      px2 <= rdrs_pkg::SPROD_W'(fx1) * rdrs_pkg::SPROD_W'(dx1);
      py2 <= rdrs_pkg::SPROD_W'(fy1) * rdrs_pkg::SPROD_W'(dy1);

      result.ray_x      <= rx2;
      result.ray_y      <= ry2;
      result.cell_x     <= rdrs_pkg::CELL_W'(player_x[rdrs_pkg::FRAC_BITS +: rdrs_pkg::MAP_BITS]);
      result.cell_y     <= rdrs_pkg::CELL_W'(player_y[rdrs_pkg::FRAC_BITS +: rdrs_pkg::MAP_BITS]);
      result.delta_x    <= dx2;
      result.delta_y    <= dy2;
      result.step_dir_x <= rx2[rdrs_pkg::RAY_W-1] ? rdrs_pkg::STEP_NEG : rdrs_pkg::STEP_POS;
      result.step_dir_y <= ry2[rdrs_pkg::RAY_W-1] ? rdrs_pkg::STEP_NEG : rdrs_pkg::STEP_POS;
      // product over one cell length, saturated to the map range
      result.side_x <= px2[rdrs_pkg::SPROD_W-1] ? '1 :
                       px2[rdrs_pkg::SPROD_W-2:rdrs_pkg::FRAC_BITS];
      result.side_y <= py2[rdrs_pkg::SPROD_W-1] ? '1 :
                       py2[rdrs_pkg::SPROD_W-2:rdrs_pkg::FRAC_BITS];
    end
  end

endmodule

[rtl/raycast_dda_ray_setup.sv]
// ray setup for one screen column per cycle; from accept to m_tvalid a column passes through
// a 27-stage camera divider, 3 ray stages, 31-stage reciprocal dividers and 3 side stages
// throughput one item per cycle; the whole pipeline advances together and holds
// while a result waits at the output
// rst clears all valid bits and loads the configuration registers with their defaults
module raycast_dda_ray_setup (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rdrs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rdrs_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [15:0]                        s_tdata,  // column[11:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // ray_x, ray_y, cell_x, cell_y, delta_x, delta_y, step_dir_x, step_dir_y, side_x, side_y
  output logic [151:0]                       m_tdata
);

  logic [rdrs_pkg::WIDTH_W-1:0]      screen_width;
  logic [rdrs_pkg::POS_W-1:0]        player_x;
  logic [rdrs_pkg::POS_W-1:0]        player_y;
  logic signed [rdrs_pkg::DIR_W-1:0] view_dir_x;
  logic signed [rdrs_pkg::DIR_W-1:0] view_dir_y;
  logic signed [rdrs_pkg::DIR_W-1:0] cam_plane_x;
  logic signed [rdrs_pkg::DIR_W-1:0] cam_plane_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= 13'd640;
      player_x     <= '0;
      player_y     <= '0;
      view_dir_x   <= 16'sd16384;
      view_dir_y   <= '0;
      cam_plane_x  <= '0;
      cam_plane_y  <= 16'sd10813;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rdrs_pkg::REG_SCREEN_WIDTH: screen_width <= cfg_wdata[rdrs_pkg::WIDTH_W-1:0];
        rdrs_pkg::REG_PLAYER_X:     player_x     <= cfg_wdata;
        rdrs_pkg::REG_PLAYER_Y:     player_y     <= cfg_wdata;
        rdrs_pkg::REG_VIEW_DIR_X:   view_dir_x   <= cfg_wdata[rdrs_pkg::DIR_W-1:0];
        rdrs_pkg::REG_VIEW_DIR_Y:   view_dir_y   <= cfg_wdata[rdrs_pkg::DIR_W-1:0];
        rdrs_pkg::REG_CAM_PLANE_X:  cam_plane_x  <= cfg_wdata[rdrs_pkg::DIR_W-1:0];
        rdrs_pkg::REG_CAM_PLANE_Y:  cam_plane_y  <= cfg_wdata[rdrs_pkg::DIR_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  logic [rdrs_pkg::CAM_NUM_W-1:0] cam_num;
  logic [rdrs_pkg::WIDTH_W-1:0]   cam_den;
  logic [rdrs_pkg::CAM_NUM_W-1:0] cam_quo;
  logic                           cam_valid;

  assign cam_num = {s_tdata[rdrs_pkg::COL_W-1:0], {(rdrs_pkg::DIR_FRAC+1){1'b0}}};
  // a zero width divides as a width of one
  assign cam_den = (screen_width == '0) ? rdrs_pkg::WIDTH_W'(1) : screen_width;

  rdrs_div #(
    .NUM_W(rdrs_pkg::CAM_NUM_W),
    .DEN_W(rdrs_pkg::WIDTH_W),
    .SB_W (1)
  ) u_cam_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .num   (cam_num),
    .den   (cam_den),
    .sb_in (s_tvalid),
    .quo   (cam_quo),
    .sb_out(cam_valid)
  );

  logic                              ray_valid;
  logic signed [rdrs_pkg::RAY_W-1:0] ray_x;
  logic signed [rdrs_pkg::RAY_W-1:0] ray_y;

  rdrs_ray u_ray (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (cam_valid),
    .quo        (cam_quo),
    .view_dir_x (view_dir_x),
    .view_dir_y (view_dir_y),
    .cam_plane_x(cam_plane_x),
    .cam_plane_y(cam_plane_y),
    .out_valid  (ray_valid),
    .ray_x      (ray_x),
    .ray_y      (ray_y)
  );

  localparam logic [rdrs_pkg::RCP_NUM_W-1:0] RCP_NUM =
    rdrs_pkg::RCP_NUM_W'(1) << (rdrs_pkg::RCP_NUM_W - 1);

  logic [rdrs_pkg::MAG_W-1:0]     mag_x, mag_y;
  logic [rdrs_pkg::RCP_NUM_W-1:0] rcp_x, rcp_y;
  logic signed [rdrs_pkg::RAY_W-1:0] rx_d, ry_d;
  logic                           rcp_valid;

  // a zero magnitude yields an all-ones quotient, which saturates downstream
  assign mag_x = ray_x[rdrs_pkg::RAY_W-1] ? (~ray_x + 1'b1) : ray_x;
  assign mag_y = ray_y[rdrs_pkg::RAY_W-1] ? (~ray_y + 1'b1) : ray_y;

  rdrs_div #(
    .NUM_W(rdrs_pkg::RCP_NUM_W),
    .DEN_W(rdrs_pkg::MAG_W),
    .SB_W (rdrs_pkg::RAY_W + 1)
  ) u_rcp_x (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .num   (RCP_NUM),
    .den   (mag_x),
    .sb_in ({ray_x, ray_valid}),
    .quo   (rcp_x),
    .sb_out({rx_d, rcp_valid})
  );

  rdrs_div #(
    .NUM_W(rdrs_pkg::RCP_NUM_W),
    .DEN_W(rdrs_pkg::MAG_W),
    .SB_W (rdrs_pkg::RAY_W)
  ) u_rcp_y (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .num   (RCP_NUM),
    .den   (mag_y),
    .sb_in (ray_y),
    .quo   (rcp_y),
    .sb_out(ry_d)
  );

  rdrs_pkg::rdrs_result_t result;

  rdrs_side u_side (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (rcp_valid),
    .quo_x    (rcp_x),
    .quo_y    (rcp_y),
    .ray_x    (rx_d),
    .ray_y    (ry_d),
    .player_x (player_x),
    .player_y (player_y),
    .out_valid(m_tvalid),
    .result   (result)
  );

  assign m_tdata = result;

endmodule

[rtl/rdrs_checker.sv]
// port-level checks of the ray setup block, bound to the top level
`include "raycast_dda_ray_setup_assert.svh"

module rdrs_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [151:0] m_tdata
);

  // a stalled result holds
  `RDRS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // outside reset, an empty output never blocks the input
  `RDRS_ASSERT_IMPL(a_ready, !m_tvalid, s_tready)

  // step sign follows the ray sign and is never zero
  `RDRS_ASSERT_IMPL(a_step_x, m_tvalid, m_tdata[100] && (m_tdata[101] == m_tdata[17]))
  `RDRS_ASSERT_IMPL(a_step_y, m_tvalid, m_tdata[102] && (m_tdata[103] == m_tdata[35]))

  // a zero x ray component gives the maximum x delta
  `RDRS_ASSERT_IMPL(a_zero_x, m_tvalid && (m_tdata[17:0] == 18'd0),
                    m_tdata[75:52] == 24'hFFFFFF)

endmodule

bind raycast_dda_ray_setup rdrs_checker u_rdrs_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
